[sv/lpf_pkg.sv]
`default_nettype none

package lpf_pkg;

  // path storage depth unless the top level says otherwise
  localparam int DEFAULT_MAX_POINTS = 256;

  // item operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // where the lookahead point came from
  localparam logic [1:0] SRC_END       = 2'd0;
  localparam logic [1:0] SRC_NEW       = 2'd1;
  localparam logic [1:0] SRC_HELD      = 2'd2;
  localparam logic [1:0] SRC_WRITE_ACK = 2'd3;

  // configuration register indexes
  localparam logic REG_PATH_LENGTH = 1'b0;
  localparam logic REG_RADIUS      = 1'b1;

  // register values after reset
  localparam logic [8:0]  PATH_LENGTH_RESET = 9'd2;
  localparam logic [30:0] RADIUS_RESET      = 31'd786432;

  // one path point, signed Q15.16
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  // request to the segment solver
  typedef struct packed {
    logic       start;
    point_t     seg_start;
    point_t     seg_end;
    point_t     robot;
    logic [29:0] half_radius;
  } seg_req_t;

  // answer from the segment solver
  typedef struct packed {
    logic   done;
    logic   hit;
    point_t look;
  } seg_rsp_t;

  // magnitude of a 33-bit signed difference
  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    logic [32:0] r;
    r = v[32] ? 33'(-v) : 33'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/lookahead_point_finder_core.sv]
// lookahead point finder core
//
// input channel (in_valid/in_stall): one transaction per item. operation 0
// stores coord_x/coord_y as path point point_index; operation 1 is a query
// with the robot position in coord_x/coord_y.
// output channel (out_valid/out_stall): exactly one result transaction per
// item, in order: nearest point index, lookahead point and its source.
// config port (cfg_we/cfg_index/cfg_data): path_length and lookahead_radius,
// to be written only while the block is idle; the block does not enforce it.
//
// a write item is stored and acknowledged through the output register. a query
// walks the path memory one point at a time, and each segment goes through the
// segment solver with its 64-step square root and 32-step divider.
// one item is in work at a time; the next one is taken no earlier than the
// cycle in which the previous result leaves the output register.
// a stalled result holds in the output register; a finished query then waits
// until that register frees up.
// reset clears the held lookahead point and restores the registers; the path
// memory keeps no reset value and must be written before it is queried.
`default_nettype none

module lookahead_point_finder_core #(
  parameter int MAX_POINTS = lpf_pkg::DEFAULT_MAX_POINTS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               operation,
  input  wire logic [7:0]         point_index,
  input  wire logic signed [31:0] coord_x,
  input  wire logic signed [31:0] coord_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              closest_index,
  output logic signed [31:0]      look_x,
  output logic signed [31:0]      look_y,
  output logic [1:0]              look_source,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);

  localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RR   = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_MX   = 4'd4;
  localparam logic [3:0] S_MY   = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_SEG  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]         state;
  logic [8:0]         path_length;
  logic [30:0]        lookahead_radius;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      last_idx;
  logic [AW-1:0]      last_c;
  logic [AW-1:0]      best_i;
  lpf_pkg::point_t    robot;
  lpf_pkg::point_t    cur;
  lpf_pkg::point_t    prev;
  lpf_pkg::point_t    hit_pt;
  lpf_pkg::point_t    held;
  lpf_pkg::point_t    rd_pt;
  lpf_pkg::point_t    wr_pt;
  logic [32:0]        dxm, dym;
  logic signed [32:0] dx_diff, dy_diff;
  logic [65:0]        d2, best_d, rr;
  logic [32:0]        mul_a, mul_b;
  logic [65:0]        mprod;
  logic               end_in;
  logic               found;
  logic               out_free;
  logic               accept;
  logic               idx_ok;
  logic               wr_en;
  logic               rd_en;
  lpf_pkg::seg_req_t  seg_req;
  lpf_pkg::seg_rsp_t  seg_rsp;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;
  assign idx_ok   = 32'(point_index) < 32'(MAX_POINTS);
  assign wr_en    = accept && operation == lpf_pkg::OP_WRITE && idx_ok;
  assign rd_en    = state == S_RR || state == S_RD;
  assign wr_pt.x  = coord_x;
  assign wr_pt.y  = coord_y;

  lpf_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(point_index)),
    .wr_data (wr_pt),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_pt)
  );

  // segment solver request
  assign seg_req.start       = state == S_CMP && idx != '0;
  assign seg_req.seg_start   = prev;
  assign seg_req.seg_end     = cur;
  assign seg_req.robot       = robot;
  assign seg_req.half_radius = lookahead_radius[30:1];

  lpf_seg u_seg (
    .clk (clk),
    .rst (rst),
    .req (seg_req),
    .rsp (seg_rsp)
  );

  // last point index from the clamped path length
  always_comb begin
    if (path_length < 9'd2) begin
      last_c = AW'(1);
    end else if (32'(path_length) > 32'(MAX_POINTS)) begin
      last_c = AW'(MAX_POINTS - 1);
    end else begin
      last_c = AW'(path_length - 9'd1);
    end
  end

  // distance to the point just read
  assign dx_diff = {robot.x[31], robot.x} - {rd_pt.x[31], rd_pt.x};
  assign dy_diff = {robot.y[31], robot.y} - {rd_pt.y[31], rd_pt.y};

  // squaring multiplier operands
  always_comb begin
    mul_a = dxm;
    mul_b = dxm;
    case (state)
      S_RR: begin
        mul_a = {2'b00, lookahead_radius};
        mul_b = {2'b00, lookahead_radius};
      end
      S_MY: begin
        mul_a = dym;
        mul_b = dym;
      end
      default: begin
        mul_a = dxm;
        mul_b = dxm;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mprod <= mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      path_length      <= lpf_pkg::PATH_LENGTH_RESET;
      lookahead_radius <= lpf_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lpf_pkg::REG_PATH_LENGTH: path_length      <= cfg_data[8:0];
        lpf_pkg::REG_RADIUS:      lookahead_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // control sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      held      <= '0;
      found     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == lpf_pkg::OP_WRITE) begin
              out_valid     <= 1'b1;
              closest_index <= '0;
              look_x        <= '0;
              look_y        <= '0;
              look_source   <= lpf_pkg::SRC_WRITE_ACK;
            end else begin
              robot.x  <= coord_x;
              robot.y  <= coord_y;
              idx      <= '0;
              last_idx <= last_c;
              found    <= 1'b0;
              state    <= S_RR;
            end
          end
        end
        S_RR: begin
          state <= S_DIFF;
        end
        S_RD: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          cur <= rd_pt;
          dxm <= lpf_pkg::abs33(dx_diff);
          dym <= lpf_pkg::abs33(dy_diff);
          if (idx == '0) begin
            rr <= mprod;
          end
          state <= S_MX;
        end
        S_MX: begin
          state <= S_MY;
        end
        S_MY: begin
          d2    <= mprod;
          state <= S_SUM;
        end
        S_SUM: begin
          d2    <= d2 + mprod;
          state <= S_CMP;
        end
        S_CMP: begin
          if (idx == '0 || d2 < best_d) begin
            best_d <= d2;
            best_i <= idx;
          end
          if (idx == last_idx) begin
            end_in <= !(rr < d2);
          end
          if (idx == '0) begin
            prev  <= cur;
            idx   <= idx + AW'(1);
            state <= S_RD;
          end else begin
            state <= S_SEG;
          end
        end
        S_SEG: begin
          if (seg_rsp.done) begin
            if (seg_rsp.hit) begin
              hit_pt <= seg_rsp.look;
              found  <= 1'b1;
            end
            prev <= cur;
            if (idx == last_idx) begin
              state <= S_FIN;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            closest_index <= 8'(best_i);
            if (end_in) begin
              look_x      <= cur.x;
              look_y      <= cur.y;
              look_source <= lpf_pkg::SRC_END;
            end else if (found) begin
              held        <= hit_pt;
              look_x      <= hit_pt.x;
              look_y      <= hit_pt.y;
              look_source <= lpf_pkg::SRC_NEW;
            end else begin
              look_x      <= held.x;
              look_y      <= held.y;
              look_source <= lpf_pkg::SRC_HELD;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a query keeps the input side closed on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == lpf_pkg::OP_QUERY) |=> in_stall)
    else $error("input taken during a query walk");

  // the nearest index never lies past the last point in use
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (best_i <= last_idx))
    else $error("nearest index beyond the path end");

  // write acknowledgements carry zero payload
  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && look_source == lpf_pkg::SRC_WRITE_ACK) |->
    (closest_index == 8'd0 && look_x == 32'sd0 && look_y == 32'sd0))
    else $error("write acknowledgement with nonzero payload");

  // the segment solver only answers while the walk waits for it
  a_seg_sync: assert property (@(posedge clk) disable iff (rst)
    seg_rsp.done |-> (state == S_SEG))
    else $error("segment result outside the wait state");

endmodule

`default_nettype wire

[sv/lpf_mem.sv]
`default_nettype none

module lpf_mem #(
  parameter int DEPTH = lpf_pkg::DEFAULT_MAX_POINTS,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire lpf_pkg::point_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output lpf_pkg::point_t      rd_data
);

  lpf_pkg::point_t mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/lpf_isqrt.sv]
`default_nettype none

module lpf_isqrt (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic [127:0] rad,
  output logic              done,
  output logic [63:0]       root
);

  logic         busy;
  logic [5:0]   cnt;
  logic [127:0] d_sh;
  logic [67:0]  rem;
  logic [67:0]  rem_sh;
  logic [67:0]  trial;

  // one result bit per cycle, two radicand bits brought down
  assign rem_sh = {rem[65:0], d_sh[127:126]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      d_sh <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      d_sh <= {d_sh[125:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[62:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[62:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[sv/lpf_frac_div.sv]
`default_nettype none

module lpf_frac_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [31:0]      quo
);

  logic        busy;
  logic [4:0]  cnt;
  logic [64:0] rem;
  logic [63:0] den_r;
  logic [64:0] rem_sh;

  // restoring division, one quotient bit per cycle, num < den
  assign rem_sh = {rem[63:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      rem   <= {1'b0, num};
      den_r <= den;
      quo   <= '0;
    end else if (busy) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem <= rem_sh - {1'b0, den_r};
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[sv/lpf_seg.sv]
`default_nettype none

module lpf_seg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lpf_pkg::seg_req_t req,
  output lpf_pkg::seg_rsp_t      rsp
);

  // sequencer states
  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_MAG  = 4'd1;
  localparam logic [3:0] T_MUL  = 4'd2;
  localparam logic [3:0] T_ABS  = 4'd3;
  localparam logic [3:0] T_DISC = 4'd4;
  localparam logic [3:0] T_SQRT = 4'd5;
  localparam logic [3:0] T_PICK = 4'd6;
  localparam logic [3:0] T_DIV  = 4'd7;
  localparam logic [3:0] T_OUT  = 4'd8;

  // multiply steps on the shared multiplier
  localparam logic [4:0] M_DXDX = 5'd0;
  localparam logic [4:0] M_DYDY = 5'd1;
  localparam logic [4:0] M_FXDX = 5'd2;
  localparam logic [4:0] M_FYDY = 5'd3;
  localparam logic [4:0] M_FXFX = 5'd4;
  localparam logic [4:0] M_FYFY = 5'd5;
  localparam logic [4:0] M_RHRH = 5'd6;
  localparam logic [4:0] M_HH0  = 5'd7;
  localparam logic [4:0] M_HH1  = 5'd8;
  localparam logic [4:0] M_HH2  = 5'd9;
  localparam logic [4:0] M_HH3  = 5'd10;
  localparam logic [4:0] M_AC0  = 5'd11;
  localparam logic [4:0] M_AC1  = 5'd12;
  localparam logic [4:0] M_AC2  = 5'd13;
  localparam logic [4:0] M_AC3  = 5'd14;
  localparam logic [4:0] M_LX   = 5'd15;
  localparam logic [4:0] M_LY   = 5'd16;

  logic [3:0]         state;
  logic [4:0]         op;
  logic               ph;
  logic signed [31:0] sx, sy;
  logic signed [31:0] dx, dy, fx, fy;
  logic signed [32:0] ewx, ewy;
  logic [29:0]        rh;
  logic [31:0]        dxm, dym, fxm, fym;
  logic               sdx, sdy, sfx, sfy;
  logic [32:0]        exm, eym;
  logic               exneg, eyneg;
  logic [63:0]        a;
  logic signed [63:0] h, c;
  logic [63:0]        hm, cm;
  logic               hneg, cneg;
  logic [127:0]       h2, ac, disc;
  logic [32:0]        t;
  logic [32:0]        offx, offy;
  logic [32:0]        op_a, op_b;
  logic [65:0]        mprod;
  logic [63:0]        p64;
  logic               sq_go, sq_done;
  logic [63:0]        s;
  logic               dv_go, dv_done;
  logic [31:0]        q;
  logic [63:0]        num;
  logic               pick_hit;
  logic [63:0]        pick_num;
  logic signed [33:0] ox_w, oy_w;
  logic signed [31:0] hsx, hsy, hex, hey, hpx, hpy;

  lpf_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (sq_go),
    .rad  (disc),
    .done (sq_done),
    .root (s)
  );

  lpf_frac_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (dv_go),
    .num  (num),
    .den  (a),
    .done (dv_done),
    .quo  (q)
  );

  // halved coordinates
  assign hsx = {req.seg_start.x[31], req.seg_start.x[31:1]};
  assign hsy = {req.seg_start.y[31], req.seg_start.y[31:1]};
  assign hex = {req.seg_end.x[31], req.seg_end.x[31:1]};
  assign hey = {req.seg_end.y[31], req.seg_end.y[31:1]};
  assign hpx = {req.robot.x[31], req.robot.x[31:1]};
  assign hpy = {req.robot.y[31], req.robot.y[31:1]};

  assign p64 = mprod[63:0];

  // shared multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (op)
      M_DXDX: begin op_a = {1'b0, dxm}; op_b = {1'b0, dxm}; end
      M_DYDY: begin op_a = {1'b0, dym}; op_b = {1'b0, dym}; end
      M_FXDX: begin op_a = {1'b0, fxm}; op_b = {1'b0, dxm}; end
      M_FYDY: begin op_a = {1'b0, fym}; op_b = {1'b0, dym}; end
      M_FXFX: begin op_a = {1'b0, fxm}; op_b = {1'b0, fxm}; end
      M_FYFY: begin op_a = {1'b0, fym}; op_b = {1'b0, fym}; end
      M_RHRH: begin op_a = {3'b0, rh};  op_b = {3'b0, rh};  end
      M_HH0:  begin op_a = {1'b0, hm[31:0]};  op_b = {1'b0, hm[31:0]};  end
      M_HH1:  begin op_a = {1'b0, hm[31:0]};  op_b = {1'b0, hm[63:32]}; end
      M_HH2:  begin op_a = {1'b0, hm[63:32]}; op_b = {1'b0, hm[31:0]};  end
      M_HH3:  begin op_a = {1'b0, hm[63:32]}; op_b = {1'b0, hm[63:32]}; end
      M_AC0:  begin op_a = {1'b0, a[31:0]};   op_b = {1'b0, cm[31:0]};  end
      M_AC1:  begin op_a = {1'b0, a[31:0]};   op_b = {1'b0, cm[63:32]}; end
      M_AC2:  begin op_a = {1'b0, a[63:32]};  op_b = {1'b0, cm[31:0]};  end
      M_AC3:  begin op_a = {1'b0, a[63:32]};  op_b = {1'b0, cm[63:32]}; end
      M_LX:   begin op_a = exm; op_b = t; end
      M_LY:   begin op_a = eym; op_b = t; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    mprod <= op_a * op_b;
  end

  // choice of the root numerator, exit root first
  always_comb begin
    pick_hit = 1'b0;
    pick_num = '0;
    if (!hneg) begin
      if (s >= hm && (s - hm) <= a) begin
        pick_hit = 1'b1;
        pick_num = s - hm;
      end
    end else if (s <= a && hm <= (a - s)) begin
      pick_hit = 1'b1;
      pick_num = s + hm;
    end
    if (!pick_hit) begin
      if (!hneg) begin
        if (hm == 64'd0 && s == 64'd0) begin
          pick_hit = 1'b1;
          pick_num = '0;
        end
      end else if (hm >= s && (hm - s) <= a) begin
        pick_hit = 1'b1;
        pick_num = hm - s;
      end
    end
  end

  // intersection point, truncated toward the segment start
  assign ox_w = exneg ? ({sx[31], sx[31], sx} - {1'b0, offx})
                      : ({sx[31], sx[31], sx} + {1'b0, offx});
  assign oy_w = eyneg ? ({sy[31], sy[31], sy} - {1'b0, offy})
                      : ({sy[31], sy[31], sy} + {1'b0, offy});

  // control sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      op       <= M_DXDX;
      ph       <= 1'b0;
      sq_go    <= 1'b0;
      dv_go    <= 1'b0;
      rsp.done <= 1'b0;
      rsp.hit  <= 1'b0;
    end else begin
      sq_go    <= 1'b0;
      dv_go    <= 1'b0;
      rsp.done <= 1'b0;
      case (state)
        T_IDLE: begin
          if (req.start) begin
            state <= T_MAG;
          end
        end
        T_MAG: begin
          op    <= M_DXDX;
          ph    <= 1'b0;
          state <= T_MUL;
        end
        T_MUL: begin
          ph <= ~ph;
          if (ph) begin
            op <= op + 5'd1;
            if (op == M_RHRH) begin
              state <= T_ABS;
            end else if (op == M_AC3) begin
              state <= T_DISC;
            end else if (op == M_LY) begin
              state <= T_OUT;
            end
          end
        end
        T_ABS: begin
          state <= T_MUL;
        end
        T_DISC: begin
          // zero-length segment or circle misses the line
          if (a == 64'd0 || (!cneg && h2 < ac)) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b0;
            state    <= T_IDLE;
          end else begin
            sq_go <= 1'b1;
            state <= T_SQRT;
          end
        end
        T_SQRT: begin
          if (sq_done) begin
            state <= T_PICK;
          end
        end
        T_PICK: begin
          if (!pick_hit) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b0;
            state    <= T_IDLE;
          end else if (pick_num >= a) begin
            op    <= M_LX;
            ph    <= 1'b0;
            state <= T_MUL;
          end else begin
            dv_go <= 1'b1;
            state <= T_DIV;
          end
        end
        T_DIV: begin
          if (dv_done) begin
            op    <= M_LX;
            ph    <= 1'b0;
            state <= T_MUL;
          end
        end
        T_OUT: begin
          rsp.done   <= 1'b1;
          rsp.hit    <= 1'b1;
          rsp.look.x <= ox_w[31:0];
          rsp.look.y <= oy_w[31:0];
          state      <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        sx  <= req.seg_start.x;
        sy  <= req.seg_start.y;
        dx  <= hex - hsx;
        dy  <= hey - hsy;
        fx  <= hsx - hpx;
        fy  <= hsy - hpy;
        ewx <= {req.seg_end.x[31], req.seg_end.x} - {req.seg_start.x[31], req.seg_start.x};
        ewy <= {req.seg_end.y[31], req.seg_end.y} - {req.seg_start.y[31], req.seg_start.y};
        rh  <= req.half_radius;
      end
      T_MAG: begin
        dxm   <= dx[31] ? 32'(-dx) : 32'(dx);
        dym   <= dy[31] ? 32'(-dy) : 32'(dy);
        fxm   <= fx[31] ? 32'(-fx) : 32'(fx);
        fym   <= fy[31] ? 32'(-fy) : 32'(fy);
        sdx   <= dx[31];
        sdy   <= dy[31];
        sfx   <= fx[31];
        sfy   <= fy[31];
        exm   <= lpf_pkg::abs33(ewx);
        eym   <= lpf_pkg::abs33(ewy);
        exneg <= ewx[32];
        eyneg <= ewy[32];
      end
      T_MUL: begin
        if (ph) begin
          case (op)
            M_DXDX: a <= p64;
            M_DYDY: a <= a + p64;
            M_FXDX: h <= (sfx ^ sdx) ? (64'd0 - p64) : p64;
            M_FYDY: h <= (sfy ^ sdy) ? (h - p64) : (h + p64);
            M_FXFX: c <= p64;
            M_FYFY: c <= c + p64;
            M_RHRH: c <= c - p64;
            M_HH0:  h2 <= {64'd0, p64};
            M_HH1:  h2 <= h2 + {32'd0, p64, 32'd0};
            M_HH2:  h2 <= h2 + {32'd0, p64, 32'd0};
            M_HH3:  h2 <= h2 + {p64, 64'd0};
            M_AC0:  ac <= {64'd0, p64};
            M_AC1:  ac <= ac + {32'd0, p64, 32'd0};
            M_AC2:  ac <= ac + {32'd0, p64, 32'd0};
            M_AC3:  ac <= ac + {p64, 64'd0};
            M_LX:   offx <= mprod[64:32];
            M_LY:   offy <= mprod[64:32];
            default: ;
          endcase
        end
      end
      T_ABS: begin
        hm   <= h[63] ? 64'(-h) : 64'(h);
        cm   <= c[63] ? 64'(-c) : 64'(c);
        hneg <= h[63];
        cneg <= c[63];
      end
      T_DISC: begin
        disc <= cneg ? (h2 + ac) : (h2 - ac);
      end
      T_PICK: begin
        num <= pick_num;
        t   <= 33'h1_0000_0000;
      end
      T_DIV: begin
        if (dv_done) begin
          t <= {1'b0, q};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
